// ===== rtl/core/image_item_layer_splitter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the image item layer splitter
// Shared concurrent checks, clocked and held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ITEM_LAYER_SPLITTER_UNIT_ASSERT_SVH
`define IMAGE_ITEM_LAYER_SPLITTER_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define IILS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define IILS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/iils_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iils_pkg
// Types and constants shared by the image item layer splitter.
// ----------------------------------------------------------------------------
package iils_pkg;

    // fixed layer layout: three given sizes plus a remainder layer
    localparam int unsigned C_NUM_LAYERS = 4;
    // highest selectable layer bound when no size list is present
    localparam int unsigned C_MAX_LAYERS = 4;
    // prefix sums of three 32-bit sizes
    localparam int unsigned C_PFX_W      = 34;

    // status codes
    localparam logic [2:0] C_ST_OK     = 3'd0;
    localparam logic [2:0] C_ST_HINT   = 3'd1;
    localparam logic [2:0] C_ST_LAYER  = 3'd2;
    localparam logic [2:0] C_ST_SELECT = 3'd3;
    localparam logic [2:0] C_ST_COUNT  = 3'd4;

    // configuration register indexes
    localparam int unsigned C_CFG_IDX_W       = 2;
    localparam logic [1:0]  C_CFG_ALLOW_PROG  = 2'd0;
    localparam logic [1:0]  C_CFG_COUNT_LIMIT = 2'd1;
    localparam logic [1:0]  C_CFG_SIZE_HINT   = 2'd2;

    // input word
    typedef struct packed {
        logic [31:0] item_id;
        logic [63:0] item_size;
        logic        has_layer_sizes;
        logic [31:0] layer_size_first;
        logic [31:0] layer_size_second;
        logic [31:0] layer_size_third;
        logic        has_layer_select;
        logic [15:0] selected_layer;
    } t_item;

    // result word
    typedef struct packed {
        logic [31:0] sample_item;
        logic [63:0] sample_offset;
        logic [63:0] sample_length;
        logic [1:0]  spatial_layer;
        logic        spatial_set;
        logic        sync_sample;
        logic        decode_all_layers;
        logic        is_progressive;
        logic [2:0]  status;
        logic        last_sample;
    } t_result;

    // classified item, one queue entry; errors carry zeros but the status
    typedef struct packed {
        logic [31:0]                            item_id;
        logic [2:0]                             status;
        logic [1:0]                             spl;
        logic                                   sps;
        logic                                   all;
        logic                                   prog;
        logic [1:0]                             last_idx;
        logic [C_NUM_LAYERS-1:0][63:0]          len;
        logic [C_NUM_LAYERS-1:0][C_PFX_W-1:0]   off;
    } t_entry;

endpackage

// ===== rtl/core/iils_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iils_front
// Accepts items, holds the configuration and classifies each item into a
// queue entry: size hint check, layer split, selection and count checks.
// ----------------------------------------------------------------------------
module iils_front import iils_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  t_item                  i_item,
    input  logic                   i_cfg_valid,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_entry                 o_entry
);

    logic        w_accept;
    logic        r_allow_prog;
    logic [31:0] r_count_limit;
    logic [63:0] r_size_hint;

    logic                                 r_a_vld;
    t_item                                r_a_item;
    logic [C_NUM_LAYERS-1:0][C_PFX_W-1:0] r_a_pfx;
    logic                                 r_a_hint_err;

    logic [2:0][31:0] w_given;
    logic [2:0]       w_nz;
    logic [2:0]       w_ge;
    logic             w_lay_err;
    logic [2:0]       w_cnt;
    logic [C_PFX_W-1:0] w_pend;
    logic [63:0]      w_rem;
    logic [C_NUM_LAYERS-1:0][63:0] w_lay;
    logic             w_sel_err;
    logic             w_count_err;
    logic             w_prog_flag;
    logic             w_prog_mode;
    logic [63:0]      w_sel_len;
    t_entry           n_entry;

    assign o_busy   = i_q_full;
    assign w_accept = i_start && !i_q_full;

    // configuration registers and input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld       <= 1'b0;
            r_allow_prog  <= 1'b0;
            r_count_limit <= '0;
            r_size_hint   <= '0;
        end else begin
            r_a_vld <= w_accept;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    C_CFG_ALLOW_PROG:  r_allow_prog  <= i_cfg_data[0];
                    C_CFG_COUNT_LIMIT: r_count_limit <= i_cfg_data[31:0];
                    C_CFG_SIZE_HINT:   r_size_hint   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // input stage: capture word, prefix sums of the given sizes, hint check
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_item     <= i_item;
            r_a_pfx[0]   <= '0;
            r_a_pfx[1]   <= C_PFX_W'(i_item.layer_size_first);
            r_a_pfx[2]   <= C_PFX_W'(i_item.layer_size_first)
                          + C_PFX_W'(i_item.layer_size_second);
            r_a_pfx[3]   <= C_PFX_W'(i_item.layer_size_first)
                          + C_PFX_W'(i_item.layer_size_second)
                          + C_PFX_W'(i_item.layer_size_third);
            r_a_hint_err <= (r_size_hint != '0) && (i_item.item_size > r_size_hint);
        end
    end

    assign w_given = {r_a_item.layer_size_third, r_a_item.layer_size_second,
                      r_a_item.layer_size_first};

    // a nonzero size must stay below what remains: prefix through it < size
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nz[i] = (w_given[i] != '0);
            w_ge[i] = (64'(r_a_pfx[i+1]) >= r_a_item.item_size);
        end
    end

    // layer split: count of layers and where the remainder starts
    always_comb begin
        w_lay_err = 1'b0;
        w_cnt     = 3'd0;
        w_pend    = '0;
        if (r_a_item.has_layer_sizes) begin
            if (!w_nz[0]) begin
                w_cnt = 3'd1;
            end else if (w_ge[0]) begin
                w_lay_err = 1'b1;
            end else if (!w_nz[1]) begin
                w_cnt  = 3'd2;
                w_pend = r_a_pfx[1];
            end else if (w_ge[1]) begin
                w_lay_err = 1'b1;
            end else if (!w_nz[2]) begin
                w_cnt  = 3'd3;
                w_pend = r_a_pfx[2];
            end else if (w_ge[2]) begin
                w_lay_err = 1'b1;
            end else begin
                w_cnt  = 3'd4;
                w_pend = r_a_pfx[3];
            end
        end
    end

    assign w_rem = r_a_item.item_size - 64'(w_pend);

    // the last layer takes the remainder, earlier ones their given size
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lay[i] = (w_cnt == 3'(i + 1)) ? w_rem : 64'(w_given[i]);
        end
        w_lay[3] = w_rem;
    end

    assign w_sel_err = r_a_item.has_layer_sizes
                     ? (r_a_item.selected_layer >= 16'(w_cnt))
                     : (r_a_item.selected_layer >= 16'(C_MAX_LAYERS));
    assign w_count_err = (r_count_limit != '0) && (32'(w_cnt) > r_count_limit);
    assign w_prog_flag = r_a_item.has_layer_sizes && !r_a_item.has_layer_select;
    assign w_prog_mode = r_allow_prog && w_prog_flag;

    // prefix length up to and including the selected layer
    always_comb begin
        if (!r_a_item.has_layer_sizes
            || (r_a_item.selected_layer == 16'(w_cnt - 3'd1))) begin
            w_sel_len = r_a_item.item_size;
        end else begin
            case (r_a_item.selected_layer[1:0])
                2'd0:    w_sel_len = 64'(r_a_pfx[1]);
                2'd1:    w_sel_len = 64'(r_a_pfx[2]);
                default: w_sel_len = 64'(r_a_pfx[3]);
            endcase
        end
    end

    // build the queue entry
    always_comb begin
        n_entry = '0;
        if (r_a_hint_err) begin
            n_entry.status = C_ST_HINT;
        end else if (w_lay_err) begin
            n_entry.status = C_ST_LAYER;
        end else if (r_a_item.has_layer_select) begin
            if (w_sel_err) begin
                n_entry.status = C_ST_SELECT;
            end else begin
                n_entry.status  = C_ST_OK;
                n_entry.item_id = r_a_item.item_id;
                n_entry.len[0]  = w_sel_len;
                n_entry.spl     = r_a_item.selected_layer[1:0];
                n_entry.sps     = 1'b1;
                n_entry.all     = 1'b1;
            end
        end else if (w_prog_mode) begin
            if (w_count_err) begin
                n_entry.status = C_ST_COUNT;
            end else begin
                n_entry.status   = C_ST_OK;
                n_entry.item_id  = r_a_item.item_id;
                n_entry.len      = w_lay;
                n_entry.off      = r_a_pfx;
                n_entry.all      = 1'b1;
                n_entry.prog     = 1'b1;
                n_entry.last_idx = 2'(w_cnt - 3'd1);
            end
        end else begin
            n_entry.status  = C_ST_OK;
            n_entry.item_id = r_a_item.item_id;
            n_entry.len[0]  = r_a_item.item_size;
            n_entry.prog    = w_prog_flag;
        end
    end

    assign o_push  = r_a_vld;
    assign o_entry = n_entry;

endmodule

// ===== rtl/core/iils_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iils_queue
// Short entry queue between front and back. Full is raised early enough to
// cover the word still in the front stage.
// ----------------------------------------------------------------------------
`include "image_item_layer_splitter_unit_assert.svh"
module iils_queue import iils_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty,
    output logic   o_full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W:0]     w_level;

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // level counts the entry about to be pushed
    assign w_level = {1'b0, r_cnt} + (CNT_W + 1)'(i_push);
    assign o_full  = (w_level >= (CNT_W + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `IILS_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && (r_cnt == CNT_W'(DEPTH)), "queue push while full")
    `IILS_ASSERT(a_q_underflow, i_clk, i_rst_n, i_pop |-> (r_cnt != '0), "queue pop while empty")

endmodule

// ===== rtl/core/iils_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iils_back
// Walks the head entry one sample per cycle into the output register and
// retires the entry with its last sample.
// ----------------------------------------------------------------------------
`include "image_item_layer_splitter_unit_assert.svh"
module iils_back import iils_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_entry  i_head,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_res_valid,
    output t_result o_result
);

    logic [1:0] r_idx;
    logic       r_out_vld;
    t_result    r_out;
    logic       w_emit;
    logic       w_last;
    t_result    n_out;

    assign w_emit = !i_empty;
    assign w_last = (r_idx == i_head.last_idx);
    assign o_pop  = w_emit && w_last;

    // sample currently addressed in the head entry
    always_comb begin
        n_out.sample_item       = i_head.item_id;
        n_out.sample_offset     = 64'(i_head.off[r_idx]);
        n_out.sample_length     = i_head.len[r_idx];
        n_out.spatial_layer     = i_head.spl;
        n_out.spatial_set       = i_head.sps;
        n_out.sync_sample       = (i_head.status == C_ST_OK) && (r_idx == 2'd0);
        n_out.decode_all_layers = i_head.all;
        n_out.is_progressive    = i_head.prog;
        n_out.status            = i_head.status;
        n_out.last_sample       = w_last;
    end

    // sample index and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_emit;
            if (o_pop) begin
                r_idx <= '0;
            end else if (w_emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_result    = r_out;

    `IILS_ASSERT(a_bk_burst, i_clk, i_rst_n, (r_out_vld && !r_out.last_sample) |=> r_out_vld, "gap inside an item's samples")
    `IILS_ASSERT(a_bk_err_last, i_clk, i_rst_n, (r_out_vld && (r_out.status != C_ST_OK)) |-> (r_out.last_sample && (r_out.sample_length == '0)), "error result not single and empty")

endmodule

// ===== rtl/core/image_item_layer_splitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_item_layer_splitter_unit
// Splits image items into decode samples: front classifies, queue decouples,
// back emits one sample per cycle.
// ----------------------------------------------------------------------------
// The first result passes the input stage register, the queue and the output register.
// Throughput: the back emitter gives one result per cycle, so an item gives one
//   result per sample (one to four); single-sample items run one per cycle while busy is low.
// busy rises when the queue, counting the word in the front stage, is full.
// Reset clears the configuration to zero and empties the queue; no wait after.
// Results are strobed for one cycle and are never held off by the receiver.
module image_item_layer_splitter_unit import iils_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  t_item                  i_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    output logic                   o_res_valid,
    output t_result                o_result
);

    logic   w_push;
    logic   w_pop;
    logic   w_empty;
    logic   w_full;
    t_entry w_entry;
    t_entry w_head;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    iils_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    iils_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    iils_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule

// ===== bench/image_item_layer_splitter_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_item_layer_splitter_unit_checker
// Watches the item, configuration and result channels of the layer splitter.
// Predicts the decode samples of each accepted item from its own copy of the
// registers and compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module image_item_layer_splitter_unit_checker import iils_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  t_item                  i_item,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_res_valid,
    input  t_result                i_result,
    output int unsigned            o_fail_count,
    output int unsigned            o_pending
);

    localparam int unsigned REPORT_LIMIT = 10;

    // register shadows
    logic        prog_enable = 1'b0;
    logic [31:0] count_limit = '0;
    logic [63:0] hint_bytes  = '0;

    t_result     expected_samples [$];
    int unsigned mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_result make_sample(input logic [31:0] id, input logic [63:0] off,
                                            input logic [63:0] len, input logic [1:0] spl,
                                            input logic sps, input logic sync,
                                            input logic all, input logic prog,
                                            input logic last);
        t_result r;
        r                   = '0;
        r.sample_item       = id;
        r.sample_offset     = off;
        r.sample_length     = len;
        r.spatial_layer     = spl;
        r.spatial_set       = sps;
        r.sync_sample       = sync;
        r.decode_all_layers = all;
        r.is_progressive    = prog;
        r.status            = C_ST_OK;
        r.last_sample       = last;
        return r;
    endfunction

    // Splits one item into layers and queues the samples it should give
    function automatic void predict_samples(input t_item it);
        logic [63:0] part [4];
        logic [31:0] given [3];
        logic [63:0] rest;
        logic [63:0] len;
        logic [63:0] off;
        int unsigned n_layers;
        logic [2:0]  err;
        logic        ended;
        logic        prog;
        t_result     r;
        given[0] = it.layer_size_first;
        given[1] = it.layer_size_second;
        given[2] = it.layer_size_third;
        for (int i = 0; i < 4; i++) part[i] = '0;
        n_layers = 0;
        ended    = 1'b0;
        err      = C_ST_OK;

        if (hint_bytes != 0 && it.item_size > hint_bytes) begin
            err = C_ST_HINT;
        end else if (it.has_layer_sizes) begin
            // each given size must leave something behind; zero takes the rest
            rest = it.item_size;
            for (int i = 0; i < 3; i++) begin
                if (!ended && err == C_ST_OK) begin
                    n_layers++;
                    if (given[i] == 0) begin
                        part[i] = rest;
                        rest    = '0;
                        ended   = 1'b1;
                    end else if ({32'd0, given[i]} >= rest) begin
                        err = C_ST_LAYER;
                    end else begin
                        part[i] = {32'd0, given[i]};
                        rest    = rest - {32'd0, given[i]};
                    end
                end
            end
            if (err == C_ST_OK && rest != 0) begin
                part[3]  = rest;
                n_layers = 4;
            end
        end

        prog = it.has_layer_sizes && !it.has_layer_select;

        if (err == C_ST_OK) begin
            if (it.has_layer_select) begin
                // prefix up to and including the selected layer
                if (n_layers != 0 ? it.selected_layer >= n_layers
                                  : it.selected_layer >= C_MAX_LAYERS) begin
                    err = C_ST_SELECT;
                end else begin
                    len = it.item_size;
                    if (n_layers != 0) begin
                        len = '0;
                        for (int i = 0; i < 4; i++)
                            if (i <= it.selected_layer) len = len + part[i];
                    end
                    expected_samples.push_back(make_sample(it.item_id, '0, len,
                        it.selected_layer[1:0], 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
                end
            end else if (prog_enable && prog) begin
                // one sample per layer, only the first one a sync sample
                if (count_limit != 0 && n_layers > count_limit) begin
                    err = C_ST_COUNT;
                end else begin
                    off = '0;
                    for (int i = 0; i < n_layers; i++) begin
                        expected_samples.push_back(make_sample(it.item_id, off, part[i],
                            2'd0, 1'b0, i == 0, 1'b1, 1'b1, i + 1 == n_layers));
                        off = off + part[i];
                    end
                end
            end else begin
                expected_samples.push_back(make_sample(it.item_id, '0, it.item_size,
                    2'd0, 1'b0, 1'b1, 1'b0, prog, 1'b1));
            end
        end

        if (err != C_ST_OK) begin
            r             = '0;
            r.status      = err;
            r.last_sample = 1'b1;
            expected_samples.push_back(r);
        end
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf({"item %h off %h len %h spl %0d sps %b sync %b all %b",
                          " prog %b st %0d last %b"},
                         r.sample_item, r.sample_offset, r.sample_length, r.spatial_layer,
                         r.spatial_set, r.sync_sample, r.decode_all_layers,
                         r.is_progressive, r.status, r.last_sample);
    endfunction

    // register writes, result comparison, then prediction of new words
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            prog_enable = 1'b0;
            count_limit = '0;
            hint_bytes  = '0;
            expected_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    C_CFG_ALLOW_PROG:  prog_enable = i_cfg_data[0];
                    C_CFG_COUNT_LIMIT: count_limit = i_cfg_data[31:0];
                    C_CFG_SIZE_HINT:   hint_bytes  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: %s", describe(i_result));
                end else begin
                    want = expected_samples.pop_front();
                    if (i_result !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(i_result));
                        end
                    end
                end
            end
            if (i_start && !i_busy) predict_samples(i_item);
        end
        o_pending <= expected_samples.size();
    end

endmodule

// ===== bench/image_item_layer_splitter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_item_layer_splitter_unit_test
// Drives directed and random image items through the layer splitter under
// several register settings, with random gaps on the item and register
// channels; a checker beside the block predicts and compares every sample.
// ----------------------------------------------------------------------------
module image_item_layer_splitter_unit_test;
    import iils_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned SETTLE_WAIT  = 16;
    localparam int unsigned GAP_PERCENT  = 23;
    localparam int unsigned PHASE_ITEMS  = 53;
    localparam int unsigned PHASE_COUNT  = 7;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_start     = 1'b0;
    t_item                  i_item      = '0;
    logic                   i_cfg_valid = 1'b0;
    logic [C_CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]            i_cfg_data  = '0;
    logic                   o_busy;
    logic                   o_cfg_ready;
    logic                   o_res_valid;
    t_result                o_result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;

    // stimulus shaping only
    logic        gaps_on  = 1'b1;
    logic [63:0] hint_now = '0;

    always #6 i_clk = ~i_clk;

    image_item_layer_splitter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    image_item_layer_splitter_unit_checker sample_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_item       (i_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_res_valid  (o_res_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // valid stays high between back-to-back words; only a gap lowers it
    task automatic write_register(input logic [C_CFG_IDX_W-1:0] index,
                                  input logic [63:0] data);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // unused upper bits carry noise
    task automatic configure(input logic prog, input logic [31:0] limit,
                             input logic [63:0] hint);
        write_register(C_CFG_ALLOW_PROG, {$urandom, $urandom} & ~64'd1 | {63'd0, prog});
        write_register(C_CFG_COUNT_LIMIT, {$urandom, limit});
        write_register(C_CFG_SIZE_HINT, hint);
        i_cfg_valid <= 1'b0;
        hint_now = hint;
    endtask

    task automatic send_item(input t_item it);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
    endtask

    // hold the sender off until every predicted sample has come back
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic t_item item_of(input logic [31:0] id, input logic [63:0] bytes,
                                      input logic listed, input logic [31:0] a,
                                      input logic [31:0] b, input logic [31:0] c,
                                      input logic picked, input logic [15:0] sel);
        t_item it;
        it.item_id           = id;
        it.item_size         = bytes;
        it.has_layer_sizes   = listed;
        it.layer_size_first  = a;
        it.layer_size_second = b;
        it.layer_size_third  = c;
        it.has_layer_select  = picked;
        it.selected_layer    = sel;
        return it;
    endfunction

    // mostly well-formed layer lists, some overflowing, some noise
    function automatic t_item make_item();
        t_item       it;
        logic [31:0] sz [3];
        logic [63:0] rest;
        logic [63:0] cap;
        int unsigned pick;
        int unsigned cut;
        it.item_id = $urandom;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: it.item_size = 64'($urandom_range(0, 5000));
            4, 5, 6:    it.item_size = {$urandom, $urandom};
            7:          it.item_size = 64'($urandom_range(0, 3));
            8:          it.item_size = hint_now + 64'($urandom_range(0, 2)) - 64'd1;
            default:    it.item_size = $urandom_range(0, 1) ? '1 : {32'd0, $urandom};
        endcase
        // keep most items inside a known total size
        if (hint_now != 0 && pick != 8 && $urandom_range(0, 9) < 8 &&
            it.item_size > hint_now)
            it.item_size = it.item_size % hint_now;

        it.has_layer_sizes = $urandom_range(0, 9) < 7;
        pick = $urandom_range(0, 9);
        cut  = (pick == 7) ? $urandom_range(0, 2) : $urandom_range(0, 3);
        rest = it.item_size;
        for (int i = 0; i < 3; i++) begin
            cap = (rest > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : rest - 64'd1;
            if (pick >= 8) begin
                sz[i] = (pick == 8) ? $urandom : 32'd0;
            end else if (i < cut) begin
                sz[i] = (rest < 2) ? 32'd0 : 32'(({$urandom, $urandom} % cap) + 64'd1);
                rest  = rest - {32'd0, sz[i]};
            end else if (i == cut) begin
                // overflow case: exactly what remains, or noise if it does not fit
                if (pick == 7)
                    sz[i] = (rest > 64'hFFFF_FFFF) ? $urandom : rest[31:0];
                else
                    sz[i] = 32'd0;
            end else begin
                sz[i] = $urandom;
            end
        end
        it.layer_size_first  = sz[0];
        it.layer_size_second = sz[1];
        it.layer_size_third  = sz[2];

        it.has_layer_select = $urandom_range(0, 99) < 35;
        it.selected_layer   = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4))
                                                         : 16'($urandom);
        return it;
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hint of 1000, limit of three samples, progressive on
        configure(1'b1, 32'd3, 64'd1000);
        send_item(item_of(32'd1, 64'd1001, 1'b0, 0, 0, 0, 1'b0, 16'd0));
        send_item(item_of(32'd2, 64'd1000, 1'b0, 0, 0, 0, 1'b0, 16'd0));
        send_item(item_of(32'd3, 64'd1000, 1'b1, 100, 200, 300, 1'b0, 16'd0));
        send_item(item_of(32'd4, 64'd1000, 1'b1, 100, 200, 0, 1'b0, 16'd0));
        send_item(item_of(32'd5, 64'd1000, 1'b1, 100, 0, 55, 1'b0, 16'd0));
        send_item(item_of(32'd6, 64'd999, 1'b1, 0, 7, 7, 1'b0, 16'd0));
        send_item(item_of(32'd7, 64'd1000, 1'b1, 1000, 0, 0, 1'b0, 16'd0));
        send_item(item_of(32'd8, 64'd1000, 1'b1, 100, 900, 0, 1'b0, 16'd0));
        send_item(item_of(32'd9, 64'd1000, 1'b1, 100, 200, 700, 1'b0, 16'd0));
        send_item(item_of(32'd10, 64'd1000, 1'b1, 100, 200, 0, 1'b1, 16'd2));
        send_item(item_of(32'd11, 64'd1000, 1'b1, 100, 200, 0, 1'b1, 16'd3));
        send_item(item_of(32'd12, 64'd1000, 1'b1, 100, 200, 300, 1'b1, 16'd3));
        send_item(item_of(32'd13, 64'd500, 1'b0, 0, 0, 0, 1'b1, 16'd0));
        send_item(item_of(32'd14, 64'd500, 1'b0, 0, 0, 0, 1'b1, 16'd3));
        send_item(item_of(32'd15, 64'd500, 1'b0, 0, 0, 0, 1'b1, 16'd4));
        send_item(item_of(32'd16, 64'd1000, 1'b1, 100, 0, 0, 1'b1, 16'hFFFF));
        send_item(item_of(32'd17, 64'd0, 1'b0, 0, 0, 0, 1'b0, 16'd0));
        send_item(item_of(32'd18, 64'd0, 1'b1, 0, 0, 0, 1'b0, 16'd0));
        drain();

        // widest sizes, progressive off
        configure(1'b0, 32'd0, '1);
        send_item(item_of('1, '1, 1'b1, '1, '1, '1, 1'b0, 16'd0));
        send_item(item_of('1, '1, 1'b1, '1, '1, '1, 1'b1, 16'd2));
        drain();

        // widest sizes, progressive on without limit
        configure(1'b1, 32'd0, 64'd0);
        send_item(item_of('1, '1, 1'b1, '1, '1, '1, 1'b0, 16'd0));
        send_item(item_of(32'h8000_0001, 64'h8000_0000_0000_0000, 1'b1,
                          32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0, 16'd0));
        drain();

        // random phases under different settings, each drained before the next
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: configure(1'b0, 32'd0, 64'd0);
                1: configure(1'b1, 32'd0, 64'd0);
                2: configure(1'b1, 32'd1, 64'($urandom_range(1, 5000)));
                3: configure(1'b1, 32'd2, {$urandom, $urandom});
                4: configure(1'b1, 32'd3, 64'd0);
                5: configure(1'b1, '1, '1);
                default: configure(1'b0, $urandom, 64'($urandom_range(0, 4000)));
            endcase
            // one phase sends its items with no gaps at all
            gaps_on = (phase != 1);
            repeat (PHASE_ITEMS) send_item(make_item());
            drain();
        end

        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== image_item_layer_splitter_unit.f =====
+incdir+rtl/core
rtl/core/iils_pkg.sv
rtl/core/iils_front.sv
rtl/core/iils_queue.sv
rtl/core/iils_back.sv
rtl/core/image_item_layer_splitter_unit.sv
bench/image_item_layer_splitter_unit_checker.sv
bench/image_item_layer_splitter_unit_test.sv
